// ===== hw/rtl/ltd_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ltd_pkg: shared types and constants of the local clock converter
// Beat structures, configuration codes, and the reciprocal constants used in
// place of division by fixed divisors throughout the pipeline.
// ----------------------------------------------------------------------------
package ltd_pkg;

	// Configuration port.
	localparam int unsigned CFG_INDEX_W = 2;
	localparam int unsigned CFG_DATA_W  = 5;
	localparam logic [CFG_INDEX_W-1:0] CFG_ZONE_HOURS       = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_TWENTY_FOUR_HOUR = 2'd1;

	// Time constants.
	localparam logic [11:0] SECS_PER_HOUR = 12'd3600;
	localparam logic [5:0]  SECS_PER_MIN  = 6'd60;
	localparam logic [4:0]  HOURS_PER_DAY = 5'd24;
	localparam logic [9:0]  DAY_DIV       = 10'd675;   // 86400 = 675 * 128
	localparam logic [16:0] SECS_PER_HOUR_W = 17'd3600;

	// Civil calendar: 400-year eras start on March 1st.
	localparam logic [15:0] ERA5_FIRST_DAY = 16'd11017;  // 2000-03-01
	localparam logic [17:0] ERA4_DOE_BIAS  = 18'd135080;
	localparam logic [17:0] ERA5_DOE_BIAS  = 18'd11017;
	localparam logic [17:0] DAYS_PER_CENT  = 18'd36524;
	localparam logic [8:0]  DAYS_PER_YEAR  = 9'd365;

	// Months counted from March.
	localparam logic [3:0] MP_MARCH     = 4'd0;
	localparam logic [3:0] MP_APRIL     = 4'd1;
	localparam logic [3:0] MP_SEPTEMBER = 4'd6;
	localparam logic [3:0] MP_OCTOBER   = 4'd7;
	localparam logic [3:0] MP_LAST      = 4'd11;

	// Last Sunday of a 31-day month falls on day 25 or later.
	localparam logic [4:0] LAST_WEEK_FIRST_DAY = 5'd25;

	// Reciprocals: floor(x / d) == (x * ceil(2^k / d)) >> k for the operand widths used.
	localparam int unsigned MS_SHIFT   = 38;
	localparam logic [28:0] MS_RECIP   = 29'(((64'd1 << MS_SHIFT) + 64'd999) / 64'd1000);
	localparam int unsigned DAY_SHIFT  = 35;
	localparam logic [25:0] DAY_RECIP  = 26'(((64'd1 << DAY_SHIFT) + 64'd674) / 64'd675);
	localparam int unsigned Q1460_SHIFT = 25;
	localparam logic [16:0] Q1460_RECIP = 17'(((64'd1 << Q1460_SHIFT) + 64'd364) / 64'd365);
	localparam int unsigned YEAR_SHIFT = 27;
	localparam logic [18:0] YEAR_RECIP = 19'(((64'd1 << YEAR_SHIFT) + 64'd364) / 64'd365);
	localparam int unsigned HOUR_SHIFT = 36;
	localparam logic [28:0] HOUR_RECIP = 29'(((64'd1 << HOUR_SHIFT) + 64'd224) / 64'd225);
	localparam int unsigned HDAY_SHIFT = 20;
	localparam logic [18:0] HDAY_RECIP = 19'(((64'd1 << HDAY_SHIFT) + 64'd2) / 64'd3);
	localparam int unsigned MIN_SHIFT  = 14;
	localparam logic [10:0] MIN_RECIP  = 11'(((64'd1 << MIN_SHIFT) + 64'd14) / 64'd15);

	// Input beat.
	typedef struct packed {
		logic [31:0] epoch_seconds;
		logic [31:0] elapsed_ms;
	} ltd_in_t;

	// Result beat.
	typedef struct packed {
		logic        time_valid;
		logic [31:0] local_seconds;
		logic [4:0]  hour_out;
		logic [5:0]  minute_out;
		logic [5:0]  second_out;
		logic        summer_time;
	} ltd_out_t;

	// Configuration registers.
	typedef struct packed {
		logic signed [4:0] zone_hours;
		logic              twenty_four_hour;
	} ltd_cfg_t;

	// UTC with its first-hour flag, era day and weekday.
	typedef struct packed {
		logic        sync;
		logic [31:0] utc;
		logic        hour0;
		logic [17:0] doe;
		logic [2:0]  wday;
	} ltd_days_t;

	// UTC with its calendar month (counted from March) and day of month.
	typedef struct packed {
		logic        sync;
		logic [31:0] utc;
		logic        hour0;
		logic [2:0]  wday;
		logic [3:0]  mp;
		logic [4:0]  mday;
	} ltd_date_t;

	// First day of year (from March 1st) of each month counted from March.
	function automatic logic [8:0] month_start(input logic [3:0] mp);
		logic [8:0] d;
		case (mp)
			4'd0:    d = 9'd0;
			4'd1:    d = 9'd31;
			4'd2:    d = 9'd61;
			4'd3:    d = 9'd92;
			4'd4:    d = 9'd122;
			4'd5:    d = 9'd153;
			4'd6:    d = 9'd184;
			4'd7:    d = 9'd214;
			4'd8:    d = 9'd245;
			4'd9:    d = 9'd275;
			4'd10:   d = 9'd306;
			4'd11:   d = 9'd337;
			default: d = 9'd0;
		endcase
		return d;
	endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/ltd_utc.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ltd_utc: UTC front end
// Forms UTC from epoch and elapsed milliseconds, splits it into whole days,
// flags the first hour of the day, and derives era day and weekday.
// Four pipeline stages.
// ----------------------------------------------------------------------------
module ltd_utc (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               stamp_valid,
	output logic               stamp_ready,
	input  ltd_pkg::ltd_in_t   stamp_beat,
	output logic               days_valid,
	input  logic               days_ready,
	output ltd_pkg::ltd_days_t days_beat
);
	import ltd_pkg::*;

	// Residue modulo 7 by folding octal digits, since 8 is 1 modulo 7.
	function automatic logic [2:0] mod7(input logic [16:0] x);
		logic [17:0] xe;
		logic [5:0]  s;
		logic [3:0]  t;
		xe = {1'b0, x};
		s = '0;
		for (int i = 0; i < 6; i++) begin
			s = s + 6'(xe[3*i +: 3]);
		end
		t = 4'(s[5:3]) + 4'(s[2:0]);
		return (t >= 4'd7) ? 3'(t - 4'd7) : t[2:0];
	endfunction

	logic v_s1, v_s2, v_s3, v_s4;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4;

	logic        sync_s1, sync_s2, sync_s3;
	logic [31:0] epoch_s1;
	logic [22:0] msq_s1;
	logic [31:0] utc_s2, utc_s3;
	logic [15:0] days_s3;
	ltd_days_t   beat_s4;

	logic [60:0] ms_prod;
	logic [50:0] day_prod;
	logic [24:0] day_rem;
	logic [16:0] sod_part;
	logic [17:0] doe;

	// A stage takes a new beat when it is empty or its beat moves on.
	assign rdy_s4 = !v_s4 || days_ready;
	assign rdy_s3 = !v_s3 || rdy_s4;
	assign rdy_s2 = !v_s2 || rdy_s3;
	assign rdy_s1 = !v_s1 || rdy_s2;
	assign stamp_ready = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= stamp_valid;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
			if (rdy_s4) v_s4 <= v_s3;
		end
	end

	// Whole seconds in the elapsed milliseconds.
	assign ms_prod = 61'(stamp_beat.elapsed_ms) * 61'(MS_RECIP);

	// Whole days: utc / 86400 as (utc / 128) / 675.
	assign day_prod = 51'(utc_s2[31:7]) * 51'(DAY_RECIP);

	// Seconds into the day, era day of the date.
	always_comb begin
		day_rem  = utc_s3[31:7] - 25'(25'(days_s3) * 25'(DAY_DIV));
		sod_part = {day_rem[9:0], utc_s3[6:0]};
		if (days_s3 >= ERA5_FIRST_DAY) begin
			doe = 18'(days_s3) - ERA5_DOE_BIAS;
		end else begin
			doe = 18'(days_s3) + ERA4_DOE_BIAS;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && stamp_valid) begin
			sync_s1  <= (stamp_beat.epoch_seconds != 32'd0);
			epoch_s1 <= stamp_beat.epoch_seconds;
			msq_s1   <= ms_prod[MS_SHIFT +: 23];
		end
		if (rdy_s2 && v_s1) begin
			sync_s2 <= sync_s1;
			utc_s2  <= epoch_s1 + 32'(msq_s1);
		end
		if (rdy_s3 && v_s2) begin
			sync_s3 <= sync_s2;
			utc_s3  <= utc_s2;
			days_s3 <= day_prod[DAY_SHIFT +: 16];
		end
		if (rdy_s4 && v_s3) begin
			beat_s4.sync  <= sync_s3;
			beat_s4.utc   <= utc_s3;
			beat_s4.hour0 <= (sod_part < SECS_PER_HOUR_W);
			beat_s4.doe   <= doe;
			beat_s4.wday  <= mod7(17'(days_s3) + 17'd4);
		end
	end

	assign days_valid = v_s4;
	assign days_beat  = beat_s4;

endmodule
`default_nettype wire

// ===== hw/rtl/ltd_civil.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ltd_civil: civil calendar stages
// Turns the era day into year of era, day of year, month counted from March
// and day of month. Five pipeline stages.
// ----------------------------------------------------------------------------
module ltd_civil (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               days_valid,
	output logic               days_ready,
	input  ltd_pkg::ltd_days_t days_beat,
	output logic               date_valid,
	input  logic               date_ready,
	output ltd_pkg::ltd_date_t date_beat
);
	import ltd_pkg::*;

	logic v_s5, v_s6, v_s7, v_s8, v_s9;
	logic rdy_s5, rdy_s6, rdy_s7, rdy_s8, rdy_s9;

	ltd_days_t   d_s5, d_s6, d_s7, d_s8;
	logic [6:0]  q1460_s5;
	logic [2:0]  qcent_s5;
	logic        eraend_s5;
	logic [17:0] n_s6;
	logic [8:0]  yoe_s7;
	logic [8:0]  doy_s8;
	ltd_date_t   beat_s9;

	logic [32:0] q1460_prod;
	logic [2:0]  qcent;
	logic [36:0] year_prod;
	logic [1:0]  ycent;
	logic [17:0] year_base;
	logic [3:0]  mp;
	logic [4:0]  mday;

	assign rdy_s9 = !v_s9 || date_ready;
	assign rdy_s8 = !v_s8 || rdy_s9;
	assign rdy_s7 = !v_s7 || rdy_s8;
	assign rdy_s6 = !v_s6 || rdy_s7;
	assign rdy_s5 = !v_s5 || rdy_s6;
	assign days_ready = rdy_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
			v_s9 <= 1'b0;
		end else begin
			if (rdy_s5) v_s5 <= days_valid;
			if (rdy_s6) v_s6 <= v_s5;
			if (rdy_s7) v_s7 <= v_s6;
			if (rdy_s8) v_s8 <= v_s7;
			if (rdy_s9) v_s9 <= v_s8;
		end
	end

	// Leap corrections of the era day: four-year and century counts.
	assign q1460_prod = 33'(days_beat.doe[17:2]) * 33'(Q1460_RECIP);
	assign qcent = 3'(days_beat.doe >= DAYS_PER_CENT)
		+ 3'(days_beat.doe >= 18'(DAYS_PER_CENT * 2))
		+ 3'(days_beat.doe >= 18'(DAYS_PER_CENT * 3))
		+ 3'(days_beat.doe >= 18'(DAYS_PER_CENT * 4));

	// Year of era.
	assign year_prod = 37'(n_s6) * 37'(YEAR_RECIP);

	// Day of year from March 1st.
	always_comb begin
		ycent = 2'(yoe_s7 >= 9'd100) + 2'(yoe_s7 >= 9'd200) + 2'(yoe_s7 >= 9'd300);
		year_base = 18'(yoe_s7) * 18'(DAYS_PER_YEAR) + 18'(yoe_s7[8:2]) - 18'(ycent);
	end

	// Month counted from March and day of month.
	always_comb begin
		mp = MP_MARCH;
		for (int i = 1; i <= int'(MP_LAST); i++) begin
			if (doy_s8 >= month_start(4'(i))) mp = 4'(i);
		end
		mday = 5'(doy_s8 - month_start(mp) + 9'd1);
	end

	always_ff @(posedge clk) begin
		if (rdy_s5 && days_valid) begin
			d_s5      <= days_beat;
			q1460_s5  <= q1460_prod[Q1460_SHIFT +: 7];
			qcent_s5  <= qcent;
			eraend_s5 <= (days_beat.doe == 18'(DAYS_PER_CENT * 4));
		end
		if (rdy_s6 && v_s5) begin
			d_s6 <= d_s5;
			n_s6 <= d_s5.doe - 18'(q1460_s5) + 18'(qcent_s5) - 18'(eraend_s5);
		end
		if (rdy_s7 && v_s6) begin
			d_s7   <= d_s6;
			yoe_s7 <= year_prod[YEAR_SHIFT +: 9];
		end
		if (rdy_s8 && v_s7) begin
			d_s8   <= d_s7;
			doy_s8 <= 9'(d_s7.doe - year_base);
		end
		if (rdy_s9 && v_s8) begin
			beat_s9.sync  <= d_s8.sync;
			beat_s9.utc   <= d_s8.utc;
			beat_s9.hour0 <= d_s8.hour0;
			beat_s9.wday  <= d_s8.wday;
			beat_s9.mp    <= mp;
			beat_s9.mday  <= mday;
		end
	end

	assign date_valid = v_s9;
	assign date_beat  = beat_s9;

endmodule
`default_nettype wire

// ===== hw/rtl/ltd_local.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ltd_local: summer-time rule and local time breakdown
// Decides summer time, applies the zone offset, and splits local seconds into
// hour, minute and second. Six pipeline stages, the last is the output register.
// ----------------------------------------------------------------------------
module ltd_local (
	input  logic               clk,
	input  logic               arst_n,
	input  ltd_pkg::ltd_cfg_t  cfg,
	input  logic               date_valid,
	output logic               date_ready,
	input  ltd_pkg::ltd_date_t date_beat,
	output logic               lt_valid,
	input  logic               lt_ready,
	output ltd_pkg::ltd_out_t  lt_beat
);
	import ltd_pkg::*;

	logic v_s10, v_s11, v_s12, v_s13, v_s14, v_s15;
	logic rdy_s10, rdy_s11, rdy_s12, rdy_s13, rdy_s14, rdy_s15;

	logic               sync_s10, sync_s11, sync_s12, sync_s13, sync_s14;
	logic               summer_s10, summer_s11, summer_s12, summer_s13, summer_s14;
	logic [31:0]        utc_s10;
	logic signed [16:0] off_s10;
	logic [31:0]        local_s11, local_s12, local_s13, local_s14;
	logic [20:0]        hl_s12, hl_s13;
	logic [11:0]        rem_s13, rem_s14;
	logic [15:0]        hday_s13;
	logic [4:0]         hour_s14;
	logic [5:0]         minute_s14;
	ltd_out_t           beat_s15;

	logic               late, sunday, summer;
	logic signed [5:0]  off_hours;
	logic [56:0]        hour_prod;
	logic [36:0]        hday_prod;
	logic [20:0]        min_prod;
	logic [4:0]         hour_disp;

	assign rdy_s15 = !v_s15 || lt_ready;
	assign rdy_s14 = !v_s14 || rdy_s15;
	assign rdy_s13 = !v_s13 || rdy_s14;
	assign rdy_s12 = !v_s12 || rdy_s13;
	assign rdy_s11 = !v_s11 || rdy_s12;
	assign rdy_s10 = !v_s10 || rdy_s11;
	assign date_ready = rdy_s10;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s10 <= 1'b0;
			v_s11 <= 1'b0;
			v_s12 <= 1'b0;
			v_s13 <= 1'b0;
			v_s14 <= 1'b0;
			v_s15 <= 1'b0;
		end else begin
			if (rdy_s10) v_s10 <= date_valid;
			if (rdy_s11) v_s11 <= v_s10;
			if (rdy_s12) v_s12 <= v_s11;
			if (rdy_s13) v_s13 <= v_s12;
			if (rdy_s14) v_s14 <= v_s13;
			if (rdy_s15) v_s15 <= v_s14;
		end
	end

	// Summer time: the day is on or after the last Sunday when a Sunday lies
	// between day 25 and today; the switch happens at 01:00 UTC.
	always_comb begin
		late   = (date_beat.mday >= LAST_WEEK_FIRST_DAY)
			&& (date_beat.wday <= 3'(date_beat.mday - LAST_WEEK_FIRST_DAY));
		sunday = (date_beat.wday == 3'd0);
		case (date_beat.mp)
			MP_MARCH:   summer = late && (!sunday || !date_beat.hour0);
			MP_OCTOBER: summer = !late || (sunday && date_beat.hour0);
			default:    summer = (date_beat.mp inside {[MP_APRIL:MP_SEPTEMBER]});
		endcase
		off_hours = 6'(cfg.zone_hours) + signed'({5'd0, summer});
	end

	// Local hours since 1970: local / 3600 as (local / 16) / 225.
	assign hour_prod = 57'(local_s11[31:4]) * 57'(HOUR_RECIP);

	// Whole days of local time: hours / 24 as (hours / 8) / 3.
	assign hday_prod = 37'(hl_s12[20:3]) * 37'(HDAY_RECIP);

	// Minutes of the hour: rem / 60 as (rem / 4) / 15.
	assign min_prod = 21'(rem_s13[11:2]) * 21'(MIN_RECIP);

	// Twelve-hour display maps 0 to 12 and 13-23 to 1-11.
	always_comb begin
		hour_disp = hour_s14;
		if (!cfg.twenty_four_hour) begin
			if (hour_s14 == 5'd0) begin
				hour_disp = 5'd12;
			end else if (hour_s14 > 5'd12) begin
				hour_disp = hour_s14 - 5'd12;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s10 && date_valid) begin
			sync_s10   <= date_beat.sync;
			summer_s10 <= summer;
			utc_s10    <= date_beat.utc;
			off_s10    <= 17'(off_hours) * 17'sd3600;
		end
		if (rdy_s11 && v_s10) begin
			sync_s11   <= sync_s10;
			summer_s11 <= summer_s10;
			local_s11  <= utc_s10 + 32'(off_s10);
		end
		if (rdy_s12 && v_s11) begin
			sync_s12   <= sync_s11;
			summer_s12 <= summer_s11;
			local_s12  <= local_s11;
			hl_s12     <= hour_prod[HOUR_SHIFT +: 21];
		end
		if (rdy_s13 && v_s12) begin
			sync_s13   <= sync_s12;
			summer_s13 <= summer_s12;
			local_s13  <= local_s12;
			hl_s13     <= hl_s12;
			rem_s13    <= 12'(local_s12 - 32'(hl_s12) * 32'(SECS_PER_HOUR));
			hday_s13   <= hday_prod[HDAY_SHIFT +: 16];
		end
		if (rdy_s14 && v_s13) begin
			sync_s14   <= sync_s13;
			summer_s14 <= summer_s13;
			local_s14  <= local_s13;
			rem_s14    <= rem_s13;
			hour_s14   <= 5'(hl_s13 - 21'(hday_s13) * 21'(HOURS_PER_DAY));
			minute_s14 <= min_prod[MIN_SHIFT +: 6];
		end
		// Output register; an unsynchronized beat reads as all zero.
		if (rdy_s15 && v_s14) begin
			if (sync_s14) begin
				beat_s15.time_valid    <= 1'b1;
				beat_s15.local_seconds <= local_s14;
				beat_s15.hour_out      <= hour_disp;
				beat_s15.minute_out    <= minute_s14;
				beat_s15.second_out    <= 6'(rem_s14 - 12'(minute_s14) * 12'(SECS_PER_MIN));
				beat_s15.summer_time   <= summer_s14;
			end else begin
				beat_s15 <= '0;
			end
		end
	end

	assign lt_valid = v_s15;
	assign lt_beat  = beat_s15;

endmodule
`default_nettype wire

// ===== hw/rtl/local_time_eu_dst.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// local_time_eu_dst: local clock with European summer time
// Converts a synchronized Unix time plus elapsed milliseconds into local time.
// ----------------------------------------------------------------------------
// The block takes one timestamp beat per clock unless utc_stall is high,
// and returns one result beat for each, in order. The pipeline depth is
// set by the chain of reciprocal multiplications (milliseconds to seconds,
// seconds to days, the civil calendar, then local hours, minutes and
// seconds), each followed by a pipeline register. Every stage holds its beat
// under stall and empty stages keep filling, so the input stalls only when
// all 15 stages are occupied and the result is held.
// Configuration writes are always accepted; change the zone or hour format
// only while no beat is in flight.
module local_time_eu_dst (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               utc_valid,
	output logic                               utc_stall,
	input  ltd_pkg::ltd_in_t                   utc_beat,
	output logic                               lt_valid,
	input  logic                               lt_stall,
	output ltd_pkg::ltd_out_t                  lt_beat,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [ltd_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [ltd_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import ltd_pkg::*;

	ltd_cfg_t  cfg_q;
	logic      utc_ready;
	logic      days_valid, days_ready;
	ltd_days_t days_beat;
	logic      date_valid, date_ready;
	ltd_date_t date_beat;

	// Configuration registers.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_ZONE_HOURS:       cfg_q.zone_hours <= cfg_data;
				CFG_TWENTY_FOUR_HOUR: cfg_q.twenty_four_hour <= cfg_data[0];
				default:              cfg_q <= cfg_q;
			endcase
		end
	end

	assign utc_stall = !utc_ready;

	ltd_utc u_utc (
		.clk         (clk),
		.arst_n      (arst_n),
		.stamp_valid (utc_valid),
		.stamp_ready (utc_ready),
		.stamp_beat  (utc_beat),
		.days_valid  (days_valid),
		.days_ready  (days_ready),
		.days_beat   (days_beat)
	);

	ltd_civil u_civil (
		.clk        (clk),
		.arst_n     (arst_n),
		.days_valid (days_valid),
		.days_ready (days_ready),
		.days_beat  (days_beat),
		.date_valid (date_valid),
		.date_ready (date_ready),
		.date_beat  (date_beat)
	);

	ltd_local u_local (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.date_valid (date_valid),
		.date_ready (date_ready),
		.date_beat  (date_beat),
		.lt_valid   (lt_valid),
		.lt_ready   (!lt_stall),
		.lt_beat    (lt_beat)
	);

	// The input may stall only with a full pipeline behind a held result.
	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		utc_stall |-> (lt_valid && lt_stall))
		else $error("input stalled while the pipeline had room");

	// An unsynchronized result carries only zeros.
	a_unsync_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(lt_valid && !lt_beat.time_valid) |->
		(lt_beat.local_seconds == 32'd0 && lt_beat.hour_out == 5'd0
		&& lt_beat.minute_out == 6'd0 && lt_beat.second_out == 6'd0
		&& !lt_beat.summer_time))
		else $error("unsynchronized result has nonzero fields");

	// A valid time has hour, minute and second in range.
	a_time_range: assert property (@(posedge clk) disable iff (!arst_n)
		(lt_valid && lt_beat.time_valid) |->
		(lt_beat.hour_out <= 5'd23 && lt_beat.minute_out <= 6'd59
		&& lt_beat.second_out <= 6'd59))
		else $error("local time field out of range");

endmodule
`default_nettype wire
